@@ rtl/core/u8u16_pkg.sv @@
// ----------------------------------------------------------------------------
// u8u16_pkg: shared types, codes and tables of the UTF-8 to UTF-16 converter
// Holds the DFA byte class function, the DFA transition table, the result
// kind codes and the structures passed between the decoder and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package u8u16_pkg;

  localparam int COUNT_WIDTH_DEF = 16;
  localparam int MAX_RESULTS     = 3;

  // DFA states: accept, reject, and seven states inside a sequence.
  localparam logic [3:0] ST_ACCEPT = 4'd0;
  localparam logic [3:0] ST_REJECT = 4'd1;
  localparam logic [3:0] ST_HIGHEST = 4'd8;

  // Result kinds.
  localparam logic [1:0] KIND_UNIT      = 2'd0;
  localparam logic [1:0] KIND_END_OK    = 2'd1;
  localparam logic [1:0] KIND_END_BAD   = 2'd2;
  localparam logic [1:0] KIND_TOO_SMALL = 2'd3;

  localparam logic [15:0] HI_SURR_BASE = 16'hD7C0;
  localparam logic [15:0] LO_SURR_BASE = 16'hDC00;
  localparam logic [5:0]  HI_SURR_TAG  = 6'b110110;
  localparam logic [5:0]  LO_SURR_TAG  = 6'b110111;

  // Transition table, indexed by state * 12 + byte class.
  localparam logic [3:0] NEXT_STATE [108] = '{
    4'd0, 4'd1, 4'd2, 4'd3, 4'd5, 4'd8, 4'd7, 4'd1, 4'd1, 4'd1, 4'd4, 4'd6,
    4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
    4'd1, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd0, 4'd1, 4'd0, 4'd1, 4'd1,
    4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd2, 4'd1, 4'd1,
    4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1,
    4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd1,
    4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3, 4'd1, 4'd3, 4'd1, 4'd1,
    4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3, 4'd1, 4'd3, 4'd1, 4'd1,
    4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1
  };

  // One result item as it leaves the block.
  typedef struct packed {
    logic [15:0] unit;
    logic [1:0]  kind;
    logic [15:0] cpts;
    logic        last;
  } res_t;

  // Per-text decoder state, apart from the code point count.
  typedef struct packed {
    logic [3:0]  dfa;
    logic [20:0] acc;
    logic [15:0] units;
    logic        stopped;
  } txt_state_t;

  // Results caused by one byte, in order from entry 0.
  typedef struct packed {
    logic [1:0]       n;
    res_t [MAX_RESULTS-1:0] res;
  } bundle_t;

  function automatic logic [3:0] byte_class(input logic [7:0] b);
    logic [3:0] c;
    if (b < 8'h80)       c = 4'd0;
    else if (b < 8'h90)  c = 4'd1;
    else if (b < 8'hA0)  c = 4'd9;
    else if (b < 8'hC0)  c = 4'd7;
    else if (b < 8'hC2)  c = 4'd8;
    else if (b < 8'hE0)  c = 4'd2;
    else if (b == 8'hE0) c = 4'd10;
    else if (b == 8'hED) c = 4'd4;
    else if (b < 8'hF0)  c = 4'd3;
    else if (b == 8'hF0) c = 4'd11;
    else if (b < 8'hF4)  c = 4'd6;
    else if (b == 8'hF4) c = 4'd5;
    else                 c = 4'd8;
    return c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/u8u16_step.sv @@
// ----------------------------------------------------------------------------
// u8u16_step: decode step for one UTF-8 byte
// Advances the DFA and the code point accumulator, checks the destination
// space and forms the up to three results that the byte causes.
// ----------------------------------------------------------------------------
`default_nettype none

module u8u16_step #(
  parameter int COUNT_WIDTH = u8u16_pkg::COUNT_WIDTH_DEF
) (
  input  wire u8u16_pkg::txt_state_t cur,
  input  wire [COUNT_WIDTH-1:0]      cur_count,
  input  wire [7:0]                  in_byte,
  input  wire                        eot,
  input  wire [15:0]                 capacity,
  output u8u16_pkg::txt_state_t      nxt,
  output logic [COUNT_WIDTH-1:0]     nxt_count,
  output u8u16_pkg::bundle_t         bund
);
  import u8u16_pkg::*;

  logic [3:0]             cls;
  logic [3:0]             st;
  logic [6:0]             tidx;
  logic [3:0]             dfa_new;
  logic [20:0]            acc_new;
  logic                   need2;
  logic [16:0]            units_sum;
  logic                   done_cp;
  logic                   emit_units;
  logic                   too_small;
  logic                   emit_end;
  logic [1:0]             n_units;
  logic [COUNT_WIDTH-1:0] count_new;
  logic [15:0]            cpts;
  res_t                   r_first;
  res_t                   r_low;
  res_t                   r_end;

  always_comb begin
    cls  = byte_class(in_byte);
    st   = (cur.dfa > ST_HIGHEST) ? ST_REJECT : cur.dfa;
    tidx = 7'(st) * 7'd12 + 7'(cls);
    dfa_new = NEXT_STATE[tidx];
    if (st != ST_ACCEPT) begin
      acc_new = {cur.acc[14:0], in_byte[5:0]};
    end else begin
      acc_new = {13'd0, (8'hFF >> cls) & in_byte};
    end

    need2     = (acc_new > 21'h00FFFF);
    units_sum = {1'b0, cur.units} + (need2 ? 17'd2 : 17'd1);
    done_cp   = !cur.stopped && (dfa_new == ST_ACCEPT);
    emit_units = done_cp && (units_sum < {1'b0, capacity});
    too_small  = done_cp && !(units_sum < {1'b0, capacity});
    emit_end   = !cur.stopped && eot && !too_small;

    if (emit_units && (cur_count != '1)) begin
      count_new = cur_count + 1'b1;
    end else begin
      count_new = cur_count;
    end
    cpts = 16'(count_new);

    r_low  = '{unit: LO_SURR_BASE + {6'd0, acc_new[9:0]}, kind: KIND_UNIT,
               cpts: cpts, last: 1'b0};
    r_end  = '{unit: 16'd0,
               kind: (dfa_new == ST_ACCEPT) ? KIND_END_OK : KIND_END_BAD,
               cpts: cpts, last: 1'b0};
    if (too_small) begin
      r_first = '{unit: 16'd0, kind: KIND_TOO_SMALL, cpts: cpts, last: 1'b0};
    end else if (need2) begin
      r_first = '{unit: HI_SURR_BASE + 16'(acc_new[20:10]), kind: KIND_UNIT,
                  cpts: cpts, last: 1'b0};
    end else begin
      r_first = '{unit: acc_new[15:0], kind: KIND_UNIT, cpts: cpts, last: 1'b0};
    end

    if (emit_units) begin
      n_units = need2 ? 2'd2 : 2'd1;
    end else begin
      n_units = too_small ? 2'd1 : 2'd0;
    end

    bund.n      = n_units + {1'b0, emit_end};
    bund.res[0] = (n_units == 2'd0) ? r_end : r_first;
    bund.res[1] = (n_units == 2'd2) ? r_low : r_end;
    bund.res[2] = r_end;
    bund.res[0].last = (bund.n == 2'd1);
    bund.res[1].last = (bund.n == 2'd2);
    bund.res[2].last = (bund.n == 2'd3);

    // The byte marking the end of the text always clears the per-text state.
    if (eot) begin
      nxt       = '{dfa: ST_ACCEPT, acc: 21'd0, units: 16'd0, stopped: 1'b0};
      nxt_count = '0;
    end else if (cur.stopped) begin
      nxt       = cur;
      nxt_count = cur_count;
    end else begin
      nxt.dfa     = dfa_new;
      nxt.acc     = acc_new;
      nxt.units   = emit_units ? units_sum[15:0] : cur.units;
      nxt.stopped = too_small;
      nxt_count   = count_new;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/utf8_to_utf16_converter.sv @@
// ----------------------------------------------------------------------------
// utf8_to_utf16_converter: streaming UTF-8 to UTF-16 converter
// Decodes a UTF-8 byte stream with the table-driven UTF-8 DFA and emits
// UTF-16 units, surrogate pairs, end-of-text status and overflow reports.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Carries
//   in_       slave      one UTF-8 byte a request, tlast marks end of text
//   out_      master     one result a request: unit or status, count, tlast
//   cfg_      write      destination capacity in UTF-16 units
//
// Each accepted byte is decoded in the cycle it arrives; its results are
// held in a three-entry result buffer and moved one a cycle into the output
// register while that register is free or being emptied, so each result
// passes the buffer and then the output register. A byte causing at most one
// result is taken every cycle while the output does not stall. A byte causing
// two or three results (a surrogate pair, possibly followed by the end
// status) holds in_tready low until the buffer is down to its last entry.
// A stall on the output side fills the output register and then the buffer,
// after which in_tready drops; no result is lost or repeated.
// Reset is synchronous and active low; it clears the text state and sets
// the capacity to its largest value. No memory needs clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_to_utf16_converter #(
  parameter int COUNT_WIDTH = u8u16_pkg::COUNT_WIDTH_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  // Input stream.
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,     // [7:0] in_byte
  input  wire         in_tlast,     // end_of_text
  // Result stream.
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [31:0] out_tdata,    // [15:0] out_unit, [31:16] code_points
  output logic [1:0]  out_tuser,    // [1:0] kind
  output logic        out_tlast,    // last
  // Configuration.
  input  wire         cfg_wr_en,
  input  wire  [15:0] cfg_wr_data   // dst_capacity
);
  import u8u16_pkg::*;

  // Destination capacity; the user must write it only while the converter is idle, the block does not enforce this.
  logic [15:0]            cap_r;

  // Per-text decoder state.
  txt_state_t             txt_r;
  txt_state_t             txt_nxt;
  logic [COUNT_WIDTH-1:0] count_r;
  logic [COUNT_WIDTH-1:0] count_nxt;

  // Result buffer: entries waiting for the output register, oldest in 0.
  res_t [MAX_RESULTS-1:0] ent_r;
  logic [1:0]             n_r;
  bundle_t                bund;

  // Output register.
  res_t                   out_r;
  logic                   out_v_r;

  logic                   in_acc;
  logic                   out_load;

  u8u16_step #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_step (
    .cur       (txt_r),
    .cur_count (count_r),
    .in_byte   (in_tdata),
    .eot       (in_tlast),
    .capacity  (cap_r),
    .nxt       (txt_nxt),
    .nxt_count (count_nxt),
    .bund      (bund)
  );

  // The buffer head moves into the output register whenever that register
  // is empty or being emptied by the downstream side.
  assign out_load = (n_r != 2'd0) && (!out_v_r || out_tready);

  // A new byte is taken when the buffer is empty, or when its last entry
  // leaves in this very cycle.
  assign in_tready = (n_r == 2'd0) || ((n_r == 2'd1) && out_load);
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= 16'hFFFF;
    end else if (cfg_wr_en) begin
      cap_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      txt_r   <= '{dfa: ST_ACCEPT, acc: 21'd0, units: 16'd0, stopped: 1'b0};
      count_r <= '0;
    end else if (in_acc) begin
      txt_r   <= txt_nxt;
      count_r <= count_nxt;
    end
  end

  // Result buffer control. An accepted byte replaces the buffer contents,
  // which are empty or just draining; otherwise entries shift towards 0.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r <= 2'd0;
    end else if (in_acc) begin
      n_r <= bund.n;
    end else if (out_load) begin
      n_r <= n_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      ent_r <= bund.res;
    end else if (out_load) begin
      ent_r[0] <= ent_r[1];
      ent_r[1] <= ent_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_load) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r <= ent_r[0];
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {out_r.cpts, out_r.unit};
  assign out_tuser  = out_r.kind;
  assign out_tlast  = out_r.last;

  // A byte with more than one result left in the buffer must hold off input.
  a_busy_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    (n_r == 2'd2 || n_r == 2'd3) |-> !in_tready)
    else $error("input taken while several results still buffered");

  // The newest buffered entry always closes its byte's run of results.
  a_tail_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (n_r != 2'd0) |-> ent_r[n_r - 2'd1].last)
    else $error("last buffered result lacks its last flag");

  // A high surrogate leaving the buffer is followed by its low surrogate.
  a_pair_intact: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && ent_r[0].kind == KIND_UNIT && ent_r[0].unit[15:10] == HI_SURR_TAG)
    |-> (n_r != 2'd1) && ent_r[1].kind == KIND_UNIT
        && ent_r[1].unit[15:10] == LO_SURR_TAG)
    else $error("surrogate pair split");

  // One unit always stays free, so the written count never reaches all ones.
  a_units_bound: assert property (@(posedge clk) disable iff (!rst_n)
    txt_r.units != 16'hFFFF)
    else $error("units written exceeds capacity bound");

endmodule

`default_nettype wire
